// ----- rtl/core/pls_pkg.sv -----
// Shared types and constants for the positional list store.
package pls_pkg;

  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Per-cycle action broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_WRITE  = 2'd2,
    OP_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/pls_cell.sv -----
// One list entry: holds its value and shifts to or from its neighbors.
module pls_cell
  import pls_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit;
  logic              above;

  assign hit   = (32'(ctrl.pos) == 32'(IDX));
  assign above = (32'(ctrl.pos) <  32'(IDX));

  // Select the next entry value from the broadcast action
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (above) begin
          data_nxt = left_data;
        end else if (hit) begin
          data_nxt = ctrl.value;
        end
      end
      OP_WRITE: begin
        if (hit) begin
          data_nxt = ctrl.value;
        end
      end
      OP_REMOVE: begin
        if (above || hit) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Hold the entry; contents are undefined until first written
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule

// ----- rtl/core/positional_list_store_core.sv -----
// Top level of the positional list store: command decode, cell row, result register.
//
// Usage:
//   The input channel carries one command per transaction: in_command
//   (0 insert, 1 update, 2 delete, 3 read), in_position and in_value.
//   The result channel returns exactly one transaction per command:
//   out_status, out_read_value (nonzero only on a successful read) and
//   out_entry_count, the number of entries after the command.
//   Entries live in a row of CAPACITY register cells. Insert and delete
//   shift every cell above the position by one place, all cells moving
//   together.
//   The result is registered and presented in the cycle after the command
//   is accepted. One command is taken per cycle unless the receiver
//   stalls; the single output register stage sets this rate.
//   A read selects its entry through an OR tree over all cells.
//   When the receiver stalls, the result register holds its transaction
//   and in_stall rises, so at most one result waits at a time.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; entry contents are left as they are and are never read
//   before being written again.
module positional_list_store_core
  import pls_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [POS_W-1:0]     in_position,
  input  logic [DATA_W-1:0]    in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [DATA_W-1:0]    out_read_value,
  output logic [CNT_OUT_W-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [1:0]           out_status_r;
  logic [DATA_W-1:0]    out_read_value_r;
  logic [CNT_OUT_W-1:0] out_entry_count_r;

  logic                 fire;
  cmd_t                 cmd;
  status_t              status;
  logic [DATA_W-1:0]    rd_value;
  logic [DATA_W-1:0]    rd_sel;
  cell_ctrl_t           ctrl;
  logic [CMP_W-1:0]     pos_c;
  logic [CMP_W-1:0]     cnt_c;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_command);
  assign pos_c    = CMP_W'(in_position);
  assign cnt_c    = CMP_W'(count_r);

  // Build the cell row; cell 0 sees zero on its left, the last cell on its right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    pls_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // Gather the addressed entry; at most one cell drives nonzero
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  // Decode the command into status, new count and the cell action
  always_comb begin
    status     = ST_OK;
    rd_value   = '0;
    count_nxt  = count_r;
    ctrl.op    = OP_HOLD;
    ctrl.pos   = in_position;
    ctrl.value = in_value;
    unique case (cmd)
      CMD_INSERT: begin
        if (count_r == '0) begin
          ctrl.op   = OP_INSERT;
          ctrl.pos  = '0;
          count_nxt = CNT_W'(1);
        end else if (cnt_c >= CMP_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = ST_RANGE;
        end else begin
          ctrl.op   = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_UPDATE: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          ctrl.op = OP_WRITE;
        end
      end
      CMD_DELETE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (count_r == CNT_W'(1)) begin
          count_nxt = '0;
        end else if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          ctrl.op   = OP_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          rd_value = rd_sel;
        end
      end
      default: status = ST_OK;
    endcase
    if (!fire) begin
      ctrl.op   = OP_HOLD;
      count_nxt = count_r;
    end
  end

  // Advance the count and the result valid flag
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on each accepted transaction
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r      <= status;
      out_read_value_r  <= rd_value;
      out_entry_count_r <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status != ST_OK) |=> (count_r == $past(count_r)))
    else $error("error status changed the count");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending result");

endmodule
